### rtl/bdq_pkg.sv
// ----------------------------------------------------------------------------
// bdq_pkg
// Request codes, result kinds and fixed port widths of the bounded deque.
// ----------------------------------------------------------------------------
package bdq_pkg;

  localparam int unsigned REQ_W     = 4;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned ENTRIES_W = 6;

  typedef enum logic [REQ_W-1:0] {
    REQ_ADD_BACK    = 4'd0,
    REQ_ADD_FRONT   = 4'd1,
    REQ_REM_FRONT   = 4'd2,
    REQ_REM_BACK    = 4'd3,
    REQ_REM_VALUE   = 4'd4,
    REQ_CLEAR       = 4'd5,
    REQ_PRINT_ALL   = 4'd6,
    REQ_PRINT_FIRST = 4'd7,
    REQ_PRINT_LAST  = 4'd8
  } req_t;

  typedef enum logic [2:0] {
    KIND_DONE  = 3'd0,
    KIND_ELEM  = 3'd1,
    KIND_EMPTY = 3'd2,
    KIND_FULL  = 3'd3,
    KIND_NONE  = 3'd4
  } kind_t;

endpackage

### rtl/bounded_deque_with_value_delete.sv
// ----------------------------------------------------------------------------
// bounded_deque_with_value_delete
// Bounded ordered list of signed words kept in a circular buffer memory.
// Adds, removes and clear put their one result word out in the cycle after
// the word is taken, and busy stays low, so such requests can follow every cycle.
// Remove-by-value and prints walk n entries through the one read port, one a
// cycle, busy high for the whole walk; the first result word passes the state,
// read data and result registers. Results cannot be stalled by the receiver.
// Reset empties the list at once; the memory itself is not cleared.
// ----------------------------------------------------------------------------
module bounded_deque_with_value_delete #(
  parameter int unsigned DEPTH = 32
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [bdq_pkg::REQ_W-1:0]             req_type,
  input  logic signed [bdq_pkg::DATA_W-1:0]     operand_value,
  output logic                                  result_strobe,
  output bdq_pkg::kind_t                        result_kind,
  output logic signed [bdq_pkg::DATA_W-1:0]     element_data,
  output logic                                  is_last,
  output logic [bdq_pkg::ENTRIES_W-1:0]         entries_now
);
  import bdq_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW:0]   DEPTH_A = (AW + 1)'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_PRINT,
    S_DEL
  } state_t;

  // Physical slot of a logical position, counted from the head slot.
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                         input logic [AW-1:0] off);
    logic [AW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= DEPTH_A) begin
      sum = sum - DEPTH_A;
    end
    return sum[AW-1:0];
  endfunction

  logic signed [DATA_W-1:0] mem [DEPTH];
  logic signed [DATA_W-1:0] rd_data;

  state_t                   state;
  logic [AW-1:0]            head;
  logic [CW-1:0]            count;
  logic [CW-1:0]            rd_idx;
  logic [CW-1:0]            left;
  logic [CW-1:0]            wr_idx;
  logic                     rd_vld;
  logic                     rd_last;
  logic signed [DATA_W-1:0] del_val;

  logic                     accept;
  logic                     full;
  logic [AW-1:0]            head_inc;
  logic [AW-1:0]            head_dec;
  logic                     k_none;
  logic [CW-1:0]            print_n;
  logic [CW-1:0]            print_base;
  logic                     keep;
  logic [CW-1:0]            kept_count;
  logic [AW-1:0]            raddr;
  logic                     we;
  logic [AW-1:0]            waddr;
  logic signed [DATA_W-1:0] wdata;

  always_comb begin
    accept     = start && !busy;
    full       = (count == DEPTH_C);
    head_inc   = (head == LAST_SLOT) ? '0 : head + 1'b1;
    head_dec   = (head == '0) ? LAST_SLOT : head - 1'b1;
    k_none     = operand_value[DATA_W-1] || (operand_value == '0);
    print_n    = ($unsigned(operand_value) >= DATA_W'(count)) ?
                 count : operand_value[CW-1:0];
    print_base = (req_type == REQ_PRINT_LAST) ? count - print_n : '0;
    keep       = (rd_data != del_val);
    kept_count = wr_idx + CW'(keep);
    raddr      = phys(head, rd_idx[AW-1:0]);

    we    = 1'b0;
    waddr = phys(head, count[AW-1:0]);
    wdata = operand_value;
    case (state)
      S_IDLE: begin
        if (accept && !full) begin
          if (req_type == REQ_ADD_BACK) begin
            we = 1'b1;
          end else if (req_type == REQ_ADD_FRONT) begin
            we    = 1'b1;
            waddr = head_dec;
          end
        end
      end
      S_DEL: begin
        if (rd_vld && keep) begin
          we    = 1'b1;
          waddr = phys(head, wr_idx[AW-1:0]);
          wdata = rd_data;
        end
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      busy          <= 1'b0;
      head          <= '0;
      count         <= '0;
      rd_vld        <= 1'b0;
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= 1'b0;
      case (state)
        S_IDLE: begin
          rd_vld <= 1'b0;
          if (accept) begin
            result_strobe <= 1'b1;
            result_kind   <= KIND_DONE;
            element_data  <= '0;
            is_last       <= 1'b1;
            entries_now   <= ENTRIES_W'(count);
            case (req_type)
              REQ_ADD_BACK: begin
                if (full) begin
                  result_kind <= KIND_FULL;
                end else begin
                  count       <= count + 1'b1;
                  entries_now <= ENTRIES_W'(count + 1'b1);
                end
              end
              REQ_ADD_FRONT: begin
                if (full) begin
                  result_kind <= KIND_FULL;
                end else begin
                  head        <= head_dec;
                  count       <= count + 1'b1;
                  entries_now <= ENTRIES_W'(count + 1'b1);
                end
              end
              REQ_REM_FRONT: begin
                if (count != '0) begin
                  head        <= head_inc;
                  count       <= count - 1'b1;
                  entries_now <= ENTRIES_W'(count - 1'b1);
                end
              end
              REQ_REM_BACK: begin
                if (count != '0) begin
                  count       <= count - 1'b1;
                  entries_now <= ENTRIES_W'(count - 1'b1);
                end
              end
              REQ_REM_VALUE: begin
                if (count != '0) begin
                  result_strobe <= 1'b0;
                  state         <= S_DEL;
                  busy          <= 1'b1;
                  rd_idx        <= '0;
                  left          <= count;
                  wr_idx        <= '0;
                  del_val       <= operand_value;
                end
              end
              REQ_CLEAR: begin
                count       <= '0;
                entries_now <= '0;
              end
              REQ_PRINT_ALL, REQ_PRINT_FIRST, REQ_PRINT_LAST: begin
                if (count == '0) begin
                  result_kind <= KIND_EMPTY;
                end else if (req_type != REQ_PRINT_ALL && k_none) begin
                  result_kind <= KIND_NONE;
                end else begin
                  result_strobe <= 1'b0;
                  state         <= S_PRINT;
                  busy          <= 1'b1;
                  rd_idx        <= print_base;
                  left          <= (req_type == REQ_PRINT_ALL) ? count : print_n;
                end
              end
              default: begin
                result_kind <= KIND_DONE;
              end
            endcase
          end
        end
        S_PRINT, S_DEL: begin
          // Issue one read a cycle; the data word comes back in the following cycle.
          if (left != '0) begin
            rd_idx  <= rd_idx + 1'b1;
            left    <= left - 1'b1;
            rd_vld  <= 1'b1;
            rd_last <= (left == CW'(1));
          end else begin
            rd_vld <= 1'b0;
          end
          if (rd_vld) begin
            if (state == S_PRINT) begin
              result_strobe <= 1'b1;
              result_kind   <= KIND_ELEM;
              element_data  <= rd_data;
              is_last       <= rd_last;
              entries_now   <= ENTRIES_W'(count);
            end else begin
              if (keep) begin
                wr_idx <= wr_idx + 1'b1;
              end
              if (rd_last) begin
                count         <= kept_count;
                result_strobe <= 1'b1;
                result_kind   <= KIND_DONE;
                element_data  <= '0;
                is_last       <= 1'b1;
                entries_now   <= ENTRIES_W'(kept_count);
              end
            end
            if (rd_last) begin
              state <= S_IDLE;
              busy  <= 1'b0;
            end
          end
        end
        default: begin
          state <= S_IDLE;
          busy  <= 1'b0;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_C)
    else $error("entry count exceeds the store depth");

  a_walk_ends_with_last: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> result_strobe && is_last)
    else $error("walk finished without a final result word");

  a_read_only_when_busy: assert property (@(posedge clk) disable iff (rst)
    rd_vld |-> busy)
    else $error("memory read returned outside a walk");

  a_full_add_flagged: assert property (@(posedge clk) disable iff (rst)
    (accept && full &&
     (req_type == REQ_ADD_BACK || req_type == REQ_ADD_FRONT))
    |=> result_strobe && result_kind == KIND_FULL)
    else $error("add to a full store was not flagged");
`endif

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bounded deque testbench
// Sends requests through the start/busy handshake and keeps its own copy of
// the list. Every request is turned into the results it should give, and
// each strobed result is checked in order against the oldest one waiting.
// A short directed run comes first, then weighted random traffic.
// ----------------------------------------------------------------------------
module testbench;
  import bdq_pkg::*;

  localparam int DEPTH = 32;
  localparam logic [REQ_W-1:0] REQ_UNUSED_LO = 4'd9;
  localparam logic [REQ_W-1:0] REQ_UNUSED_HI = 4'd15;
  localparam logic signed [DATA_W-1:0] MAX_VAL = 32'sh7fffffff;
  localparam logic signed [DATA_W-1:0] MIN_VAL = 32'sh80000000;

  typedef struct {
    kind_t                      kind;
    logic signed [DATA_W-1:0]   data;
    logic                       last;
    logic [ENTRIES_W-1:0]       entries;
  } deque_result_t;

  logic                     clk;
  logic                     rst;
  logic                     start;
  logic                     busy;
  logic [REQ_W-1:0]         req_type;
  logic signed [DATA_W-1:0] operand_value;
  logic                     result_strobe;
  kind_t                    result_kind;
  logic signed [DATA_W-1:0] element_data;
  logic                     is_last;
  logic [ENTRIES_W-1:0]     entries_now;

  logic signed [DATA_W-1:0] mirror_list[$];
  deque_result_t            pending_results[$];
  int                       errors = 0;
  int                       idle_pct = 0;

  bounded_deque_with_value_delete #(
    .DEPTH(DEPTH)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .req_type(req_type),
    .operand_value(operand_value),
    .result_strobe(result_strobe),
    .result_kind(result_kind),
    .element_data(element_data),
    .is_last(is_last),
    .entries_now(entries_now)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("testbench: errors");
    $finish;
  end

  task automatic report_mismatch(input string what);
    errors++;
    if (errors <= 100) begin
      $display("MISMATCH at %0t: %s", $realtime, what);
    end
  endtask

  function automatic void push_result(kind_t kind, logic signed [DATA_W-1:0] data,
                                      logic last);
    deque_result_t r;
    r.kind = kind;
    r.data = data;
    r.last = last;
    r.entries = ENTRIES_W'(mirror_list.size());
    pending_results.push_back(r);
  endfunction

  // Updates the list copy for one accepted word and queues its results.
  function automatic void apply_request(logic [REQ_W-1:0] req,
                                        logic signed [DATA_W-1:0] val);
    logic signed [DATA_W-1:0] kept[$];
    int n;
    int first;
    case (req)
      REQ_ADD_BACK, REQ_ADD_FRONT: begin
        if (mirror_list.size() >= DEPTH) begin
          push_result(KIND_FULL, '0, 1'b1);
        end else begin
          if (req == REQ_ADD_BACK) mirror_list.push_back(val);
          else mirror_list.push_front(val);
          push_result(KIND_DONE, '0, 1'b1);
        end
      end
      REQ_REM_FRONT: begin
        if (mirror_list.size() > 0) void'(mirror_list.pop_front());
        push_result(KIND_DONE, '0, 1'b1);
      end
      REQ_REM_BACK: begin
        if (mirror_list.size() > 0) void'(mirror_list.pop_back());
        push_result(KIND_DONE, '0, 1'b1);
      end
      REQ_REM_VALUE: begin
        foreach (mirror_list[i]) begin
          if (mirror_list[i] != val) kept.push_back(mirror_list[i]);
        end
        mirror_list = kept;
        push_result(KIND_DONE, '0, 1'b1);
      end
      REQ_CLEAR: begin
        mirror_list.delete();
        push_result(KIND_DONE, '0, 1'b1);
      end
      REQ_PRINT_ALL, REQ_PRINT_FIRST, REQ_PRINT_LAST: begin
        if (mirror_list.size() == 0) begin
          push_result(KIND_EMPTY, '0, 1'b1);
        end else if (req != REQ_PRINT_ALL && val <= 0) begin
          push_result(KIND_NONE, '0, 1'b1);
        end else begin
          n = mirror_list.size();
          if (req != REQ_PRINT_ALL && val < n) n = val;
          first = (req == REQ_PRINT_LAST) ? mirror_list.size() - n : 0;
          for (int i = 0; i < n; i++) begin
            push_result(KIND_ELEM, mirror_list[first + i], i == n - 1);
          end
        end
      end
      default: push_result(KIND_DONE, '0, 1'b1);
    endcase
  endfunction

  // Leaves start high on return, so a following word can go out back to back when no idle cycles are drawn.
  task automatic send_word(input logic [REQ_W-1:0] req, input logic signed [DATA_W-1:0] val);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    req_type <= req;
    operand_value <= val;
    do @(posedge clk); while (busy !== 1'b0);
    apply_request(req, val);
  endtask

  always @(posedge clk) begin : check_results
    deque_result_t want;
    if (!rst && result_strobe !== 1'b0) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected word kind=%0d data=%0d last=%b entries=%0d",
                                  result_kind, element_data, is_last, entries_now));
      end else begin
        want = pending_results.pop_front();
        if (result_strobe !== 1'b1 || result_kind !== want.kind ||
            element_data !== want.data || is_last !== want.last ||
            entries_now !== want.entries) begin
          report_mismatch($sformatf(
            "got kind=%0d data=%0d last=%b entries=%0d, want %0d %0d %b %0d",
            result_kind, element_data, is_last, entries_now,
            want.kind, want.data, want.last, want.entries));
        end
      end
    end
  end

  function automatic logic signed [DATA_W-1:0] pick_value();
    logic signed [DATA_W-1:0] v;
    case ($urandom_range(9))
      0, 1, 2: v = $urandom_range(3);
      3: v = -$signed($urandom_range(1, 3));
      4: v = $urandom_range(1) ? MAX_VAL : MIN_VAL;
      5, 6: v = (mirror_list.size() > 0) ?
                mirror_list[$urandom_range(mirror_list.size() - 1)] : $urandom();
      default: v = $urandom();
    endcase
    return v;
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_count();
    logic signed [DATA_W-1:0] k;
    case ($urandom_range(9))
      0: k = 0;
      1: k = $urandom();
      2: k = -$signed($urandom_range(1, 5));
      default: k = $urandom_range(1, DEPTH + 4);
    endcase
    return k;
  endfunction

  function automatic logic [REQ_W-1:0] pick_request();
    int r;
    r = $urandom_range(99);
    if (r < 25) return REQ_ADD_BACK;
    if (r < 45) return REQ_ADD_FRONT;
    if (r < 53) return REQ_REM_FRONT;
    if (r < 61) return REQ_REM_BACK;
    if (r < 71) return REQ_REM_VALUE;
    if (r < 74) return REQ_CLEAR;
    if (r < 82) return REQ_PRINT_ALL;
    if (r < 89) return REQ_PRINT_FIRST;
    if (r < 96) return REQ_PRINT_LAST;
    return REQ_W'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI));
  endfunction

  task automatic test_empty_list();
    send_word(REQ_PRINT_ALL, 0);
    send_word(REQ_PRINT_FIRST, 5);
    send_word(REQ_PRINT_LAST, 0);
    send_word(REQ_REM_FRONT, 0);
    send_word(REQ_REM_BACK, 0);
    send_word(REQ_REM_VALUE, 0);
  endtask

  task automatic test_extremes_and_prints();
    send_word(REQ_ADD_BACK, MAX_VAL);
    send_word(REQ_ADD_FRONT, MIN_VAL);
    send_word(REQ_ADD_BACK, 0);
    send_word(REQ_ADD_BACK, -1);
    send_word(REQ_ADD_FRONT, -1);
    send_word(REQ_PRINT_FIRST, 0);
    send_word(REQ_PRINT_LAST, -1);
    send_word(REQ_PRINT_LAST, MIN_VAL);
    send_word(REQ_PRINT_FIRST, 2);
    send_word(REQ_PRINT_LAST, 100);
    send_word(REQ_PRINT_FIRST, MAX_VAL);
  endtask

  task automatic test_remove_value();
    // Two copies of -1 sit at both ends, so compaction moves the middle.
    send_word(REQ_REM_VALUE, -1);
    send_word(REQ_REM_VALUE, 12345);
    send_word(REQ_PRINT_ALL, 0);
  endtask

  task automatic test_unused_and_clear();
    send_word(REQ_UNUSED_LO, MAX_VAL);
    send_word(REQ_UNUSED_HI, MIN_VAL);
    send_word(REQ_REM_FRONT, 0);
    send_word(REQ_REM_BACK, 0);
    send_word(REQ_CLEAR, 0);
    send_word(REQ_PRINT_ALL, 0);
  endtask

  // Mostly single random requests, with an occasional burst of adds that
  // runs the list past full so dropped adds show up.
  task automatic test_random_traffic(input int pct, input int count);
    int sent;
    int burst;
    logic [REQ_W-1:0] req;
    sent = 0;
    idle_pct = pct;
    while (sent < count) begin
      if ($urandom_range(99) < 2) begin
        burst = DEPTH - mirror_list.size() + $urandom_range(1, 3);
        repeat (burst) begin
          send_word($urandom_range(1) ? REQ_ADD_BACK : REQ_ADD_FRONT, pick_value());
        end
        sent += burst;
      end else begin
        req = pick_request();
        send_word(req, (req == REQ_PRINT_FIRST || req == REQ_PRINT_LAST) ?
                       pick_count() : pick_value());
        sent++;
      end
    end
  endtask

  initial begin
    rst <= 1'b1;
    start <= 1'b0;
    req_type <= '0;
    operand_value <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    idle_pct = 38;
    test_empty_list();
    test_extremes_and_prints();
    test_remove_value();
    test_unused_and_clear();
    test_random_traffic(38, 140);
    test_random_traffic(52, 140);
    test_random_traffic(0, 140);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DEPTH + 8) @(posedge clk);
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
